// ===== src/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int WORD_W      = 32;
	localparam int ADDR_W      = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = PTR_W + 1;
	localparam int DIV_CNT_W   = $clog2(WORD_W);
	localparam int OPC_W       = 5;
	localparam int ST_W        = 3;
	localparam int KIND_W      = 2;
	localparam int S_TDATA_W   = 72;
	localparam int M_TDATA_W   = 56;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH   = 5'd0,
		OP_ADD    = 5'd1,
		OP_SUB    = 5'd2,
		OP_MUL    = 5'd3,
		OP_DIV    = 5'd4,
		OP_JMP    = 5'd5,
		OP_JEQ    = 5'd6,
		OP_JNQ    = 5'd7,
		OP_JGT    = 5'd8,
		OP_JLT    = 5'd9,
		OP_GET    = 5'd10,
		OP_SET    = 5'd11,
		OP_DUP    = 5'd12,
		OP_POP    = 5'd13,
		OP_PPOS   = 5'd14,
		OP_SIZE   = 5'd15,
		OP_SWAP   = 5'd16,
		OP_DBG    = 5'd17,
		OP_PRINT  = 5'd18,
		OP_CPRINT = 5'd19,
		OP_READ   = 5'd20,
		OP_CREAD  = 5'd21
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_DIV0  = 3'd3,
		ST_INDEX = 3'd4
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE = 2'd0,
		KIND_NUM  = 2'd1,
		KIND_CHAR = 2'd2
	} kind_t;

	// operand needs of one opcode
	typedef struct packed {
		logic [1:0] need;  // entries that must be on the stack
		logic [1:0] nrd;   // entries read from the top
		logic       push;  // net push of one entry
	} dec_t;

	function automatic dec_t decode(opcode_t op);
		dec_t d;
		d = '{need: 2'd0, nrd: 2'd0, push: 1'b0};
		unique case (op)
			OP_PUSH, OP_PPOS, OP_SIZE, OP_READ, OP_CREAD: d.push = 1'b1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SET, OP_SWAP: begin
				d.need = 2'd2;
				d.nrd  = 2'd2;
			end
			OP_JEQ, OP_JNQ, OP_JGT, OP_JLT: begin
				d.need = 2'd3;
				d.nrd  = 2'd3;
			end
			OP_JMP, OP_GET, OP_PRINT, OP_CPRINT: begin
				d.need = 2'd1;
				d.nrd  = 2'd1;
			end
			OP_DUP: begin
				d.need = 2'd1;
				d.nrd  = 2'd1;
				d.push = 1'b1;
			end
			OP_POP: d.need = 2'd1;
			default: ;
		endcase
		return d;
	endfunction

endpackage

// ===== src/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                         | tuser
// s_*     | in  | opcode 5, immediate 32, read_value 32       | -
// m_*     | out | next_ip 16, out_value 32, status 3          | out_kind 2
//
// the stack lives in one synchronous ram (one write, one read a cycle, registered read data);
// operands are read one per cycle from the top in S_READ; push, pop, dbg, ppos, size, read,
// cread, underflow and overflow go from S_IDLE straight to S_DONE, the others pass S_READ and S_EXEC;
// get and swap add a state (S_FETCH, S_SWAP), div adds the radix-2 divider (S_DIV, S_DVWR) unless y is zero
// arst_n clears stack depth and ip; stack contents stay undefined until pushed
// a result waits in the output register while the next transaction runs; a second one holds input

module stack_machine_execute_unit
	import smx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, immediate, read_value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // next_ip, out_value, status
	output logic [KIND_W-1:0]    m_tuser    // out_kind
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_READ  = 8'b0000_0010,
		S_EXEC  = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_DVWR  = 8'b0001_0000,
		S_FETCH = 8'b0010_0000,
		S_SWAP  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	opcode_t              op_q;
	cnt_t                 count_q;
	addr_t                ip_q;
	logic [1:0]           nrd_q;
	logic [1:0]           rcnt_q;
	word_t                opnd_q [3];
	addr_t                res_ip_q;
	word_t                res_val_q;
	kind_t                res_kind_q;
	status_t              res_st_q;
	word_t                dv_rem_q;
	word_t                dv_quo_q;
	word_t                dv_den_q;
	logic                 dv_neg_q;
	logic [DIV_CNT_W-1:0] dv_cnt_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [KIND_W-1:0]    m_tuser_q;

	word_t mem [STACK_DEPTH];
	word_t mem_rdata;
	logic  mem_we;
	ptr_t  mem_wa;
	word_t mem_wd;
	logic  mem_re;
	ptr_t  mem_ra;

	opcode_t in_op;
	word_t   in_imm;
	word_t   in_rv;
	dec_t    dec;
	logic    acc;
	logic    under;
	logic    over;
	word_t   push_val;
	ptr_t    cnt_ptr;
	ptr_t    top_ptr;
	ptr_t    sec_ptr;
	ptr_t    rd_ptr;
	word_t   y_w;
	word_t   x_w;
	word_t   alu;
	word_t   prod;
	logic    get_bad;
	logic    set_bad;
	logic    take;
	logic    out_free;
	logic [WORD_W:0] dv_trial;
	logic [WORD_W:0] dv_diff;

	assign in_op  = opcode_t'(s_tdata[OPC_W-1:0]);
	assign in_imm = s_tdata[OPC_W+WORD_W-1:OPC_W];
	assign in_rv  = s_tdata[OPC_W+2*WORD_W-1:OPC_W+WORD_W];
	assign dec    = decode(in_op);

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign under    = count_q < CNT_W'(dec.need);
	assign over     = dec.push && (count_q == CNT_W'(STACK_DEPTH));
	assign out_free = !m_tvalid_q || m_tready;

	assign cnt_ptr = count_q[PTR_W-1:0];
	assign top_ptr = cnt_ptr - PTR_W'(1);
	assign sec_ptr = cnt_ptr - PTR_W'(2);
	assign rd_ptr  = cnt_ptr - PTR_W'(rcnt_q) - PTR_W'(1);

	assign y_w  = opnd_q[0];
	assign x_w  = opnd_q[1];
	assign prod = x_w * y_w;

	// top entry is the index for get and set
	assign get_bad = y_w[WORD_W-1] || (y_w >= WORD_W'(count_q - CNT_W'(1)));
	assign set_bad = y_w[WORD_W-1] || (y_w >= WORD_W'(count_q - CNT_W'(2)));

	assign dv_trial = {dv_rem_q, dv_quo_q[WORD_W-1]};
	assign dv_diff  = dv_trial - {1'b0, dv_den_q};

	always_comb begin
		unique case (in_op)
			OP_READ, OP_CREAD: push_val = in_rv;
			OP_PPOS:           push_val = WORD_W'(ip_q);
			OP_SIZE:           push_val = WORD_W'(count_q);
			default:           push_val = in_imm;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_ADD:  alu = x_w + y_w;
			OP_SUB:  alu = x_w - y_w;
			default: alu = prod;
		endcase
	end

	// conditional jumps: n on top, then y, then x
	always_comb begin
		unique case (op_q)
			OP_JEQ:  take = (opnd_q[2] == opnd_q[1]);
			OP_JNQ:  take = (opnd_q[2] != opnd_q[1]);
			OP_JGT:  take = $signed(opnd_q[1]) < $signed(opnd_q[2]);
			OP_JLT:  take = $signed(opnd_q[2]) < $signed(opnd_q[1]);
			default: take = 1'b0;
		endcase
	end

	// ram access; reads start only after the previous write, so no same-entry overlap
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_ptr;
		mem_wd = x_w;
		mem_re = 1'b0;
		mem_ra = top_ptr;
		unique case (state_q)
			S_IDLE: begin
				if (acc && !under && !over) begin
					if (dec.push && dec.nrd == 2'd0) begin
						mem_we = 1'b1;
						mem_wd = push_val;
					end else if (dec.nrd != 2'd0) begin
						mem_re = 1'b1;
					end
				end
			end
			S_READ: begin
				if (rcnt_q != nrd_q) begin
					mem_re = 1'b1;
					mem_ra = rd_ptr;
				end
			end
			S_EXEC: begin
				unique case (op_q)
					OP_ADD, OP_SUB, OP_MUL: begin
						mem_we = 1'b1;
						mem_wa = sec_ptr;
						mem_wd = alu;
					end
					OP_SET: begin
						mem_we = !set_bad;
						mem_wa = y_w[PTR_W-1:0];
					end
					OP_DUP: begin
						mem_we = 1'b1;
						mem_wd = y_w;
					end
					OP_SWAP: begin
						mem_we = 1'b1;
						mem_wa = sec_ptr;
						mem_wd = y_w;
					end
					OP_GET: begin
						mem_re = !get_bad;
						mem_ra = y_w[PTR_W-1:0];
					end
					default: ;
				endcase
			end
			S_DVWR: begin
				mem_we = 1'b1;
				mem_wa = sec_ptr;
				mem_wd = dv_neg_q ? (WORD_W'(0) - dv_quo_q) : dv_quo_q;
			end
			S_FETCH: begin
				mem_we = 1'b1;
				mem_wa = top_ptr;
				mem_wd = mem_rdata;
			end
			S_SWAP: begin
				mem_we = 1'b1;
				mem_wa = top_ptr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_ra];
		end
	end

	// operand and divider payload
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			opnd_q[rcnt_q - 2'd1] <= mem_rdata;
		end
		if (state_q == S_EXEC) begin
			dv_rem_q <= '0;
			dv_quo_q <= x_w[WORD_W-1] ? (WORD_W'(0) - x_w) : x_w;
			dv_den_q <= y_w[WORD_W-1] ? (WORD_W'(0) - y_w) : y_w;
			dv_neg_q <= x_w[WORD_W-1] ^ y_w[WORD_W-1];
		end else if (state_q == S_DIV) begin
			if (!dv_diff[WORD_W]) begin
				dv_rem_q <= dv_diff[WORD_W-1:0];
				dv_quo_q <= {dv_quo_q[WORD_W-2:0], 1'b1};
			end else begin
				dv_rem_q <= dv_trial[WORD_W-1:0];
				dv_quo_q <= {dv_quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_PUSH;
			count_q    <= '0;
			ip_q       <= '0;
			nrd_q      <= '0;
			rcnt_q     <= '0;
			dv_cnt_q   <= '0;
			res_ip_q   <= '0;
			res_val_q  <= '0;
			res_kind_q <= KIND_NONE;
			res_st_q   <= ST_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// in S_DONE the output register is either still held or reloaded below
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q       <= in_op;
						nrd_q      <= dec.nrd;
						rcnt_q     <= 2'd1;
						res_ip_q   <= ip_q + ADDR_W'(1);
						res_val_q  <= '0;
						res_kind_q <= KIND_NONE;
						res_st_q   <= under ? ST_UNDER : (over ? ST_OVER : ST_OK);
						state_q    <= (!under && !over && dec.nrd != 2'd0) ? S_READ : S_DONE;
						if (!under && !over) begin
							if (dec.push && dec.nrd == 2'd0) begin
								count_q <= count_q + CNT_W'(1);
							end else if (in_op == OP_POP) begin
								count_q <= count_q - CNT_W'(1);
							end
						end
					end
				end
				S_READ: begin
					if (rcnt_q == nrd_q) begin
						state_q <= S_EXEC;
					end else begin
						rcnt_q <= rcnt_q + 2'd1;
					end
				end
				S_EXEC: begin
					if (op_q == OP_SWAP) begin
						state_q <= S_SWAP;
					end else if (op_q == OP_DIV && y_w != '0) begin
						state_q <= S_DIV;
					end else if (op_q == OP_GET && !get_bad) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_DONE;
					end
					unique case (op_q)
						OP_ADD, OP_SUB, OP_MUL, OP_JMP: begin
							count_q <= count_q - CNT_W'(1);
							if (op_q == OP_JMP) begin
								res_ip_q <= y_w[ADDR_W-1:0];
							end
						end
						OP_DIV: begin
							if (y_w == '0) begin
								res_st_q <= ST_DIV0;
							end else begin
								dv_cnt_q <= DIV_CNT_W'(WORD_W - 1);
							end
						end
						OP_JEQ, OP_JNQ, OP_JGT, OP_JLT: begin
							count_q <= count_q - CNT_W'(3);
							if (take) begin
								res_ip_q <= y_w[ADDR_W-1:0];
							end
						end
						OP_GET: begin
							if (get_bad) begin
								res_st_q <= ST_INDEX;
							end
						end
						OP_SET: begin
							if (set_bad) begin
								res_st_q <= ST_INDEX;
							end else begin
								count_q <= count_q - CNT_W'(2);
							end
						end
						OP_DUP: count_q <= count_q + CNT_W'(1);
						OP_PRINT: begin
							res_val_q  <= y_w;
							res_kind_q <= KIND_NUM;
							count_q    <= count_q - CNT_W'(1);
						end
						OP_CPRINT: begin
							res_val_q  <= WORD_W'(y_w[7:0]);
							res_kind_q <= KIND_CHAR;
							count_q    <= count_q - CNT_W'(1);
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (dv_cnt_q == '0) begin
						state_q <= S_DVWR;
					end else begin
						dv_cnt_q <= dv_cnt_q - DIV_CNT_W'(1);
					end
				end
				S_DVWR: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_FETCH, S_SWAP: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({res_st_q, res_val_q, res_ip_q});
						m_tuser_q  <= res_kind_q;
						ip_q       <= res_ip_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("ram read and write in the same cycle");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && out_free |=> m_tvalid_q && (state_q == S_IDLE))
		else $error("finished result not loaded into output register");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (dv_cnt_q == '0) |=> (state_q == S_DVWR))
		else $error("divider did not hand over its quotient");

	a_err_no_print: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (m_tdata_q[M_TDATA_W-6:ADDR_W+WORD_W] != ST_OK) |->
		(m_tuser_q == KIND_NONE))
		else $error("print reported together with an error status");

endmodule
